/* hdl/rch_pkg.sv */
// shared types and constants for the regime classifier
package rch_pkg;

    localparam int unsigned FEAT_W  = 17;
    localparam int unsigned Q15_W   = 16;
    localparam int unsigned BONUS_W = 15;
    localparam int unsigned BEST_W  = 13;

    localparam logic [Q15_W-1:0]   ONE_Q15    = 16'd32768;
    localparam logic [14:0]        W_STRENGTH = 15'd22938;
    localparam logic [14:0]        W_AUTOCORR = 15'd9830;
    localparam logic [12:0]        W_WHIPSAW  = 13'd6554;
    localparam logic [BONUS_W-1:0] BONUS_MAX  = 15'd16384;
    localparam logic [Q15_W-1:0]   LOW_BEST   = 16'd6554;

    typedef enum logic [1:0] {
        REGIME_RANGING  = 2'd0,
        REGIME_TRENDING = 2'd1,
        REGIME_VOLATILE = 2'd2
    } regime_t;

    typedef logic [Q15_W-1:0] q15_t;

    // raw scores that do not depend on stored state
    typedef struct packed {
        q15_t trend;
        q15_t volat;
    } scores_t;

    // choice and unscaled confidence
    typedef struct packed {
        regime_t           regime;
        q15_t              conf;
        logic [BEST_W-1:0] best;
        logic              low;
    } sel_t;

endpackage

/* hdl/rch_scores.sv */
// clamping of the features and the trend and volatile scores
module rch_scores
    import rch_pkg::*;
(
    input  logic signed [FEAT_W-1:0] strength,
    input  logic signed [FEAT_W-1:0] volatility,
    input  logic signed [FEAT_W-1:0] autocorrelation,
    output scores_t                  scores
);

    localparam logic signed [FEAT_W-1:0] POS_ONE = 17'sd32768;
    localparam logic signed [FEAT_W-1:0] NEG_ONE = -17'sd32768;

    q15_t                     ds;
    q15_t                     vol;
    logic signed [FEAT_W-1:0] ac;
    q15_t                     contrib;
    q15_t                     neg_ac;
    logic [30:0]              prod_s;
    logic [30:0]              prod_a;
    logic [30:0]              trend_sum;
    logic [27:0]              prod_b;
    logic [16:0]              volat_sum;

    always_comb
    begin
        // clamp strength and volatility to 0..1, autocorrelation to -1..1
        if (strength < 0)
            ds = '0;
        else if (strength > POS_ONE)
            ds = ONE_Q15;
        else
            ds = strength[Q15_W-1:0];

        if (volatility < 0)
            vol = '0;
        else if (volatility > POS_ONE)
            vol = ONE_Q15;
        else
            vol = volatility[Q15_W-1:0];

        if (autocorrelation < NEG_ONE)
            ac = NEG_ONE;
        else if (autocorrelation > POS_ONE)
            ac = POS_ONE;
        else
            ac = autocorrelation;

        contrib = Q15_W'(17'(ac + POS_ONE) >> 1);

        prod_s    = 31'(W_STRENGTH) * 31'(ds);
        prod_a    = 31'(W_AUTOCORR) * 31'(contrib);
        trend_sum = prod_s + prod_a;
        if (trend_sum[30:15] > ONE_Q15)
            scores.trend = ONE_Q15;
        else
            scores.trend = trend_sum[30:15];

        // whipsaw boost only for negative autocorrelation
        neg_ac = (ac < 0) ? Q15_W'(-ac) : '0;
        prod_b = 28'(W_WHIPSAW) * 28'(neg_ac);
        volat_sum = {1'b0, vol} + 17'(prod_b[27:15]);
        if (volat_sum > {1'b0, ONE_Q15})
            scores.volat = ONE_Q15;
        else
            scores.volat = volat_sum[Q15_W-1:0];
    end

endmodule

/* hdl/rch_select.sv */
// ranging score, hysteresis choice and unscaled confidence
module rch_select
    import rch_pkg::*;
(
    input  scores_t            scores,
    input  logic [BONUS_W-1:0] bonus_cfg,
    input  logic               seen_first,
    input  regime_t            current_regime,
    output sel_t               sel
);

    q15_t               rng_score;
    logic [BONUS_W-1:0] bonus;
    logic [16:0]        a_range;
    logic [16:0]        a_trend;
    logic [16:0]        a_vol;
    logic [16:0]        lead_score;
    q15_t               s0;
    q15_t               s1;
    q15_t               s2;
    q15_t               t;
    q15_t               diff;
    logic [16:0]        conf2;

    always_comb
    begin
        rng_score = ONE_Q15 - ((scores.trend > scores.volat) ? scores.trend : scores.volat);

        bonus   = (bonus_cfg > BONUS_MAX) ? BONUS_MAX : bonus_cfg;
        a_range = {1'b0, rng_score};
        a_trend = {1'b0, scores.trend};
        a_vol   = {1'b0, scores.volat};
        if (seen_first)
        begin
            case (current_regime)
                REGIME_RANGING:  a_range = a_range + 17'(bonus);
                REGIME_TRENDING: a_trend = a_trend + 17'(bonus);
                REGIME_VOLATILE: a_vol   = a_vol + 17'(bonus);
                default:         ;
            endcase
        end

        // strict compares keep the earlier regime on a tie
        sel.regime = REGIME_RANGING;
        lead_score = a_range;
        if (a_trend > lead_score)
        begin
            sel.regime = REGIME_TRENDING;
            lead_score = a_trend;
        end
        if (a_vol > lead_score)
            sel.regime = REGIME_VOLATILE;

        // top two of the raw scores
        s0 = scores.trend;
        s1 = rng_score;
        s2 = scores.volat;
        if (s1 > s0)
        begin
            t = s0; s0 = s1; s1 = t;
        end
        if (s2 > s0)
        begin
            t = s0; s0 = s2; s2 = t;
        end
        if (s2 > s1)
        begin
            t = s1; s1 = s2; s2 = t;
        end

        diff  = s0 - s1;
        conf2 = {diff, 1'b0};
        sel.conf = (conf2 > {1'b0, ONE_Q15}) ? ONE_Q15 : conf2[Q15_W-1:0];
        sel.low  = (s0 < LOW_BEST);
        sel.best = s0[BEST_W-1:0];
    end

endmodule

/* hdl/rch_conf.sv */
// low-score scaling of the confidence, conf * best / 0.2
module rch_conf
    import rch_pkg::*;
(
    input  sel_t sel,
    output q15_t confidence
);

    logic [28:0] prod;
    logic [31:0] prod5;

    always_comb
    begin
        prod  = 29'(sel.conf) * 29'(sel.best);
        prod5 = {1'b0, prod, 2'b00} + 32'(prod);
        confidence = sel.low ? prod5[30:15] : sel.conf;
    end

endmodule

/* hdl/regime_classifier_hysteresis.sv */
// top level of the market regime classifier with hysteresis
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------------
//  s        | in        | s_tvalid, s_tready | s_tdata: strength, volatility, autocorr
//  m        | out       | m_tvalid, m_tready | m_tdata: regime, confidence
//  cfg      | in        | cfg_wr_en          | cfg_wr_data: hysteresis bonus
//
//  one item per cycle while m_tready keeps up; four register stages (input,
//  scores, choice, output) lie between acceptance and m_tvalid
//  the stored regime is updated in the choice stage, one item per cycle unless
//  stalled, so consecutive items see each other's choice in order
//  rst_n clears valids, the stored regime, the first-item flag and the bonus
//  each stage holds while the next one is full and stalled; an empty stage
//  keeps taking items, so s_tready only drops once the whole pipe is backed up
module regime_classifier_hysteresis
    import rch_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [16:0] directional strength, [33:17] volatility, [50:34] autocorrelation, zero pad
    input  logic [55:0]        s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [1:0] regime, [17:2] confidence, zero pad
    output logic [23:0]        m_tdata,
    input  logic               cfg_wr_en,
    input  logic [BONUS_W-1:0] cfg_wr_data
);

    // stage enables: a stage loads when it is empty or its successor moves
    logic en_out;
    logic en_s2;
    logic en_s1;
    logic en_in;

    // control state
    logic               in_valid_reg;
    logic               s1_valid_reg;
    logic               s2_valid_reg;
    logic               out_valid_reg;
    regime_t            current_regime_reg;
    logic               seen_first_reg;
    logic [BONUS_W-1:0] bonus_reg;

    // payload
    logic signed [FEAT_W-1:0] ds_reg;
    logic signed [FEAT_W-1:0] vol_reg;
    logic signed [FEAT_W-1:0] ac_reg;
    scores_t                  scores_reg;
    sel_t                     sel_reg;
    regime_t                  out_regime_reg;
    q15_t                     out_conf_reg;

    scores_t scores_next;
    sel_t    sel_next;
    q15_t    conf_next;

    assign en_out   = !out_valid_reg || m_tready;
    assign en_s2    = !s2_valid_reg || en_out;
    assign en_s1    = !s1_valid_reg || en_s2;
    assign en_in    = !in_valid_reg || en_s1;
    assign s_tready = en_in;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_conf_reg, out_regime_reg};

    // feature clamp and state-free scores
    rch_scores u_scores
    (
        .strength        (ds_reg),
        .volatility      (vol_reg),
        .autocorrelation (ac_reg),
        .scores          (scores_next)
    );

    // hysteresis choice against the stored regime
    rch_select u_select
    (
        .scores         (scores_reg),
        .bonus_cfg      (bonus_reg),
        .seen_first     (seen_first_reg),
        .current_regime (current_regime_reg),
        .sel            (sel_next)
    );

    // confidence scaling when the best score is weak
    rch_conf u_conf
    (
        .sel        (sel_reg),
        .confidence (conf_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            s1_valid_reg       <= 1'b0;
            s2_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            current_regime_reg <= REGIME_RANGING;
            seen_first_reg     <= 1'b0;
            bonus_reg          <= '0;
        end
        else
        begin
            if (en_in)
                in_valid_reg <= s_tvalid;
            if (en_s1)
                s1_valid_reg <= in_valid_reg;
            if (en_s2)
                s2_valid_reg <= s1_valid_reg;
            if (en_out)
                out_valid_reg <= s2_valid_reg;

            // the choice becomes the stored regime as the item leaves the score stage
            if (en_s2 && s1_valid_reg)
            begin
                current_regime_reg <= sel_next.regime;
                seen_first_reg     <= 1'b1;
            end

            if (cfg_wr_en)
                bonus_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_in)
        begin
            ds_reg  <= $signed(s_tdata[16:0]);
            vol_reg <= $signed(s_tdata[33:17]);
            ac_reg  <= $signed(s_tdata[50:34]);
        end
        if (en_s1)
            scores_reg <= scores_next;
        if (en_s2)
            sel_reg <= sel_next;
        if (en_out)
        begin
            out_regime_reg <= sel_reg.regime;
            out_conf_reg   <= conf_next;
        end
    end

`ifndef SYNTHESIS
    // a result never carries the unused regime code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (m_tdata[1:0] != 2'd3))
        else $error("result regime code out of range");

    // confidence never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_conf_reg <= ONE_Q15))
        else $error("confidence above one");

    // before the first item the stored regime stays at ranging
    assert property (@(posedge clk) disable iff (!rst_n)
        !seen_first_reg |-> (current_regime_reg == REGIME_RANGING))
        else $error("stored regime moved before first item");

    // an empty input stage always takes an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while input stage empty");

    // the stored regime changes only when an item passes the choice stage
    assert property (@(posedge clk) disable iff (!rst_n)
        !(en_s2 && s1_valid_reg) |=> $stable(current_regime_reg))
        else $error("stored regime changed without an item");
`endif

endmodule

/* test/tb.sv */
// self-checking testbench for the regime classifier with hysteresis
`timescale 1ns / 100ps

module tb
    import rch_pkg::*;
();

    // q1.15 constants of the scoring rules
    localparam int     Q_ONE            = 32768;
    localparam longint TREND_W_STRENGTH = 22938;    // 0.7, rounded so the pair sums to one
    localparam longint TREND_W_AUTOCORR = 9830;     // 0.3
    localparam longint WHIPSAW_W        = 6554;     // 0.2
    localparam longint BONUS_CAP        = 16384;    // 0.5
    localparam longint LOW_BEST_LIMIT   = 6554;     // 0.2

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 229;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 40;

    // bonus for each random phase, -1 means a random register value
    localparam int BONUS_PLAN [PHASES] = '{0, 32767, 1, 16384, 16385, -1, 8192, -1};

    // field values at the corners of the 17-bit q2.15 range and of the clamps
    localparam logic [16:0] CORNER_VALUES [10] = '{
        17'h10000, 17'h1FFFF, 17'h00000, 17'h00001, 17'h07FFF,
        17'h08000, 17'h08001, 17'h0FFFF, 17'h18000, 17'h17FFF
    };

    // hand-picked items: strength, volatility, autocorrelation
    localparam int DIRECTED_ITEMS [20][3] = '{
        '{16500, 0, 0},            // first item: trend barely ahead, no bonus may apply
        '{16500, 0, 0},            // trending now holds the bonus
        '{16000, 0, 0},            // ranging ahead on raw score, bonus keeps trending
        '{-65536, -65536, -65536}, // field minimums, all clamped
        '{65535, 65535, 65535},    // field maximums, scores saturate
        '{32768, 0, 32768},        // exactly one
        '{0, 16384, 0},            // ranging and volatile tie
        '{16384, 0, 0},            // ranging and trending tie
        '{0, 4915, 0},             // trending and volatile tie
        '{0, 32768, -32768},       // volatile saturates with the whipsaw boost
        '{0, 30000, -32768},
        '{40000, -5, 50000},       // out of range on every field
        '{-1, 65535, -50000},
        '{20000, 20000, 0},
        '{20000, 19000, -10000},
        '{8000, 8000, -1},
        '{1, 1, 1},
        '{32767, 0, -1},
        '{0, 0, 32768},            // trend from autocorrelation alone
        '{0, 0, 0}
    };

    typedef struct packed {
        regime_t regime;
        q15_t    conf;
    } verdict_t;

    function automatic int fit(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // tracks the classifier state and the queue of pending verdicts
    class regime_scoreboard;
        logic [BONUS_W-1:0] bonus_reg;
        regime_t            held_regime;
        bit                 seen_item;
        verdict_t           verdict_q[$];
        int unsigned        mismatches;
        int unsigned        accepted;
        int unsigned        checked;
        int unsigned        regime_count [3];

        function new();
            bonus_reg    = '0;
            held_regime  = REGIME_RANGING;
            seen_item    = 1'b0;
            mismatches   = 0;
            accepted     = 0;
            checked      = 0;
            regime_count = '{0, 0, 0};
        endfunction

        function void set_bonus(logic [BONUS_W-1:0] value);
            bonus_reg = value;
        endfunction

        function int unsigned pending();
            return verdict_q.size();
        endfunction

        // classify one accepted item and queue its verdict
        function void note_input(logic [55:0] data);
            int       ds;
            int       vol;
            int       ac;
            longint   contrib;
            longint   trend;
            longint   boost;
            longint   volat;
            longint   range_s;
            longint   bonus;
            longint   biased_range;
            longint   biased_trend;
            longint   biased_vol;
            longint   top;
            longint   s0;
            longint   s1;
            longint   s2;
            longint   swap;
            longint   conf;
            regime_t  pick;
            verdict_t v;

            ds  = fit($signed(data[16:0]), 0, Q_ONE);
            vol = fit($signed(data[33:17]), 0, Q_ONE);
            ac  = fit($signed(data[50:34]), -Q_ONE, Q_ONE);

            contrib = (ac + Q_ONE) >> 1;
            trend   = (TREND_W_STRENGTH * ds + TREND_W_AUTOCORR * contrib) >> 15;
            if (trend > Q_ONE)
                trend = Q_ONE;
            boost = (ac < 0) ? ((-ac) * WHIPSAW_W) >> 15 : 0;
            volat = vol + boost;
            if (volat > Q_ONE)
                volat = Q_ONE;
            range_s = Q_ONE - ((trend > volat) ? trend : volat);

            // hysteresis bonus for the stored regime, never on the first item
            bonus        = (bonus_reg > BONUS_CAP) ? BONUS_CAP : bonus_reg;
            biased_range = range_s;
            biased_trend = trend;
            biased_vol   = volat;
            if (seen_item)
            begin
                case (held_regime)
                    REGIME_RANGING:  biased_range += bonus;
                    REGIME_TRENDING: biased_trend += bonus;
                    REGIME_VOLATILE: biased_vol   += bonus;
                    default: ;
                endcase
            end

            // strict compares, earlier candidate wins ties
            pick = REGIME_RANGING;
            top  = biased_range;
            if (biased_trend > top)
            begin
                pick = REGIME_TRENDING;
                top  = biased_trend;
            end
            if (biased_vol > top)
                pick = REGIME_VOLATILE;

            // confidence from the gap between the two highest raw scores
            s0 = trend;
            s1 = range_s;
            s2 = volat;
            if (s1 > s0)
            begin
                swap = s0; s0 = s1; s1 = swap;
            end
            if (s2 > s0)
            begin
                swap = s0; s0 = s2; s2 = swap;
            end
            if (s2 > s1)
            begin
                swap = s1; s1 = s2; s2 = swap;
            end
            conf = 2 * (s0 - s1);
            if (conf > Q_ONE)
                conf = Q_ONE;
            if (s0 < LOW_BEST_LIMIT)
                conf = (conf * s0 * 5) >> 15;

            held_regime = pick;
            seen_item   = 1'b1;

            v.regime = pick;
            v.conf   = conf[15:0];
            verdict_q.push_back(v);
            accepted++;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("ERROR at %0t ns: %s", $time, what);
        endtask

        task check_result(logic [23:0] data);
            verdict_t want;
            if (verdict_q.size() == 0)
            begin
                report_mismatch($sformatf("result %h arrived with nothing pending", data));
                return;
            end
            want = verdict_q.pop_front();
            checked++;
            if (data[1:0] != want.regime)
                report_mismatch($sformatf("result %0d regime %0d, predicted %0d",
                                          checked, data[1:0], want.regime));
            if (data[17:2] != want.conf)
                report_mismatch($sformatf("result %0d confidence %0d, predicted %0d",
                                          checked, data[17:2], want.conf));
            regime_count[int'(want.regime)]++;
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [55:0]        s_tdata;     // [16:0] strength, [33:17] volatility, [50:34] autocorr
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;     // [1:0] regime, [17:2] confidence
    logic               cfg_wr_en;
    logic [BONUS_W-1:0] cfg_wr_data;

    regime_scoreboard sb = new();

    // flow-control mix of the current phase, percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;

    // random walk state, keeps scores drifting across the decision boundaries
    int walk_ds  = 16384;
    int walk_vol = 12000;
    int walk_ac  = 0;

    int unsigned quiet_cycles = 0;

    regime_classifier_hysteresis DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver backpressure, changed on the falling edge
    always @(negedge clk)
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // every result handshake is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("regime_classifier_hysteresis: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [55:0] pack_features(logic [16:0] ds, logic [16:0] vol,
                                                  logic [16:0] ac);
        return {5'b0, ac, vol, ds};
    endfunction

    // called on a falling edge, returns on the falling edge after acceptance
    task automatic send_item(input logic [55:0] data);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(data);
        @(negedge clk);
    endtask

    // bonus writes only once the pipe has drained
    task automatic write_bonus(input logic [BONUS_W-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_bonus(value);
    endtask

    // mostly drifting features, then uniform in range, raw 17-bit noise and corners
    task automatic random_features(output logic [55:0] data);
        int unsigned pick;
        int          ds;
        int          vol;
        int          ac;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            walk_ds  = fit(walk_ds + int'($urandom_range(4000)) - 2000, -800, Q_ONE + 800);
            walk_vol = fit(walk_vol + int'($urandom_range(4000)) - 2000, -800, Q_ONE + 800);
            walk_ac  = fit(walk_ac + int'($urandom_range(6000)) - 3000,
                           -Q_ONE - 800, Q_ONE + 800);
            ds  = walk_ds;
            vol = walk_vol;
            ac  = walk_ac;
        end
        else if (pick < 80)
        begin
            ds  = $urandom_range(Q_ONE);
            vol = $urandom_range(Q_ONE);
            ac  = int'($urandom_range(2 * Q_ONE)) - Q_ONE;
        end
        else if (pick < 92)
        begin
            ds  = $urandom;
            vol = $urandom;
            ac  = $urandom;
        end
        else
        begin
            ds  = int'(CORNER_VALUES[$urandom_range(9)]);
            vol = int'(CORNER_VALUES[$urandom_range(9)]);
            ac  = int'(CORNER_VALUES[$urandom_range(9)]);
        end
        data = pack_features(17'(ds), 17'(vol), 17'(ac));
    endtask

    initial
    begin
        logic [55:0]        item;
        logic [BONUS_W-1:0] bonus_value;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part with the bonus at its top legal value
        write_bonus(15'd16384);
        for (int i = 0; i < 20; i++)
            send_item(pack_features(17'(DIRECTED_ITEMS[i][0]), 17'(DIRECTED_ITEMS[i][1]),
                                    17'(DIRECTED_ITEMS[i][2])));

        // random phases, each with its own bonus and flow-control mix
        for (int p = 0; p < PHASES; p++)
        begin
            bonus_value = (BONUS_PLAN[p] < 0) ? BONUS_W'($urandom_range(32767))
                                              : BONUS_W'(BONUS_PLAN[p]);
            write_bonus(bonus_value);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 85; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 85; end
                default: begin gap_pct = 7; stall_pct = 7; end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                random_features(item);
                send_item(item);
            end
        end

        // drain, then keep watching for stray results
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d items over %0d bonus settings and four flow-control mixes",
                 sb.accepted, PHASES + 1);
        $display("regimes seen: ranging %0d, trending %0d, volatile %0d; errors %0d",
                 sb.regime_count[0], sb.regime_count[1], sb.regime_count[2], sb.mismatches);
        if (sb.mismatches == 0)
            $display("regime_classifier_hysteresis: match");
        else
            $display("regime_classifier_hysteresis: mismatch");
        $finish;
    end

endmodule

/* regime_classifier_hysteresis.f */
hdl/rch_pkg.sv
hdl/rch_scores.sv
hdl/rch_select.sv
hdl/rch_conf.sv
hdl/regime_classifier_hysteresis.sv
test/tb.sv
